// ===== hdl/jsu_pkg.sv =====
// types, constants and decode helpers shared by the string unescaper modules
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_CONT = 8'h80;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_MASK6 = 8'h3F;
	localparam logic [15:0] UTF8_ONE_LIM = 16'h0080;
	localparam logic [15:0] UTF8_TWO_LIM = 16'h0800;
	localparam logic [2:0] HEX_MAX = 3'd4;

	typedef enum logic [1:0] {
		MODE_AWAIT = 2'd0,
		MODE_TEXT  = 2'd1,
		MODE_ESC   = 2'd2,
		MODE_HEX   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic       bad;
	} res_t;

	// all results caused by one input item, cnt of them in use
	typedef struct packed {
		res_t [3:0] res;
		logic [2:0] cnt;
	} desc_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_of(input logic [7:0] b);
		hex_t h;
		h = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.ok = 1'b1;
			h.val = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.ok = 1'b1;
			h.val = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.ok = 1'b1;
			h.val = 4'(b - 8'h37);
		end
		return h;
	endfunction

	function automatic desc_t push_res(input desc_t d, input logic [7:0] data,
			input logic valid, input logic done, input logic bad);
		desc_t r;
		r = d;
		r.res[d.cnt[1:0]] = '{data: data, valid: valid, done: done, bad: bad};
		r.cnt = d.cnt + 3'd1;
		return r;
	endfunction

	function automatic desc_t push_utf8(input desc_t d, input logic [15:0] v);
		desc_t r;
		r = d;
		if (v < UTF8_ONE_LIM) begin
			r = push_res(r, v[7:0], 1'b1, 1'b0, 1'b0);
		end else if (v < UTF8_TWO_LIM) begin
			r = push_res(r, UTF8_LEAD2 | {3'b000, v[10:6]}, 1'b1, 1'b0, 1'b0);
			r = push_res(r, UTF8_CONT | (v[7:0] & UTF8_MASK6), 1'b1, 1'b0, 1'b0);
		end else begin
			r = push_res(r, UTF8_LEAD3 | {4'h0, v[15:12]}, 1'b1, 1'b0, 1'b0);
			r = push_res(r, UTF8_CONT | ({2'b00, v[11:6]} & UTF8_MASK6), 1'b1, 1'b0, 1'b0);
			r = push_res(r, UTF8_CONT | (v[7:0] & UTF8_MASK6), 1'b1, 1'b0, 1'b0);
		end
		return r;
	endfunction

	// plain string byte: end, start of escape, or literal
	function automatic desc_t push_text(input desc_t d, input logic [7:0] b);
		desc_t r;
		r = d;
		if (b == CH_NUL || b == CH_QUOTE) begin
			r = push_res(r, 8'h00, 1'b0, 1'b1, 1'b0);
		end else if (b != CH_BSLASH) begin
			r = push_res(r, b, 1'b1, 1'b0, 1'b0);
		end
		return r;
	endfunction

	function automatic mode_t text_mode(input logic [7:0] b);
		mode_t m;
		if (b == CH_NUL || b == CH_QUOTE) begin
			m = MODE_AWAIT;
		end else if (b == CH_BSLASH) begin
			m = MODE_ESC;
		end else begin
			m = MODE_TEXT;
		end
		return m;
	endfunction

endpackage

// ===== hdl/json_string_unescaper.sv =====
// top level of the json string unescaper: front end, burst queue, back end
// the results of a byte are written into the burst queue and offered from its head
// input: one byte per cycle while the queue is not full; results leave one per cycle
// while out_ready is high, and a byte gives up to four results, walked by the back end
// a four-entry burst queue lets input continue while results drain
// reset clears the escape state and empties the queue; no payload is cleared
module json_string_unescaper import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_done,
	output logic       malformed,
	output logic       last_of_item
);

	logic  q_full, q_empty, q_push, q_pop;
	desc_t q_desc, q_head;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (q_desc)
	);

	jsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.string_done  (string_done),
		.malformed    (malformed),
		.last_of_item (last_of_item)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("burst pushed into full queue");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_item |=> out_valid)
		else $error("result burst broken off");

	a_malformed_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && malformed |-> string_done && last_of_item && !byte_valid)
		else $error("malformed result not a lone end marker");

	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> q_head.cnt != 3'd0 && q_head.cnt <= 3'd4)
		else $error("queued burst with bad count");
`endif

endmodule

// ===== hdl/jsu_front.sv =====
// front end: escape state machine, turns each input byte into a result burst
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       q_push,
	output desc_t      q_desc
);

	mode_t       mode_q, mode_d;
	logic [2:0]  hcnt_q, hcnt_d;
	logic [15:0] hval_q, hval_d;
	hex_t        hx;
	logic        accept;

	assign hx = hex_of(in_byte);
	assign in_ready = !q_full;
	assign accept = in_valid && !q_full;
	assign q_push = accept && (q_desc.cnt != 3'd0);

	// next state
	always_comb begin
		mode_d = mode_q;
		hcnt_d = hcnt_q;
		hval_d = hval_q;
		unique case (mode_q)
			MODE_AWAIT: begin
				if (in_byte == CH_QUOTE) mode_d = MODE_TEXT;
			end
			MODE_TEXT: begin
				mode_d = text_mode(in_byte);
			end
			MODE_ESC: begin
				if (in_byte == CH_NUL) begin
					mode_d = MODE_AWAIT;
				end else if (in_byte == CH_U) begin
					mode_d = MODE_HEX;
					hcnt_d = 3'd0;
					hval_d = 16'h0000;
				end else begin
					mode_d = MODE_TEXT;
				end
			end
			MODE_HEX: begin
				if (hx.ok && hcnt_q < HEX_MAX) begin
					hval_d = {hval_q[11:0], hx.val};
					hcnt_d = hcnt_q + 3'd1;
					if (hcnt_d >= HEX_MAX) begin
						hcnt_d = 3'd0;
						hval_d = 16'h0000;
						mode_d = MODE_TEXT;
					end
				end else begin
					hcnt_d = 3'd0;
					hval_d = 16'h0000;
					mode_d = text_mode(in_byte);
				end
			end
			default: mode_d = MODE_AWAIT;
		endcase
	end

	// outputs: results caused by this byte
	always_comb begin
		q_desc = '0;
		unique case (mode_q)
			MODE_AWAIT: begin
				if (in_byte != CH_QUOTE) q_desc = push_res(q_desc, 8'h00, 1'b0, 1'b1, 1'b1);
			end
			MODE_TEXT: begin
				q_desc = push_text(q_desc, in_byte);
			end
			MODE_ESC: begin
				case (in_byte)
					CH_NUL: q_desc = push_res(q_desc, 8'h00, 1'b0, 1'b1, 1'b0);
					CH_N:   q_desc = push_res(q_desc, CH_LF, 1'b1, 1'b0, 1'b0);
					CH_R:   q_desc = push_res(q_desc, CH_CR, 1'b1, 1'b0, 1'b0);
					CH_T:   q_desc = push_res(q_desc, CH_TAB, 1'b1, 1'b0, 1'b0);
					CH_U:   q_desc = '0;
					default: q_desc = push_res(q_desc, in_byte, 1'b1, 1'b0, 1'b0);
				endcase
			end
			MODE_HEX: begin
				if (hx.ok && hcnt_q < HEX_MAX) begin
					if (hcnt_q + 3'd1 >= HEX_MAX) begin
						q_desc = push_utf8(q_desc, {hval_q[11:0], hx.val});
					end
				end else begin
					// escape cut short: emit value, then treat byte as text
					q_desc = push_utf8(q_desc, hval_q);
					q_desc = push_text(q_desc, in_byte);
				end
			end
			default: q_desc = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_AWAIT;
			hcnt_q <= 3'd0;
			hval_q <= 16'h0000;
		end else if (accept) begin
			mode_q <= mode_d;
			hcnt_q <= hcnt_d;
			hval_q <= hval_d;
		end
	end

endmodule

// ===== hdl/jsu_queue.sv =====
// short queue of result bursts between front and back end
module jsu_queue import jsu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output desc_t head
);

	desc_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop) rptr_q <= rptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/jsu_back.sv =====
// back end: walks the head burst and hands out one result item per cycle while out_ready is high
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  desc_t      head,
	input  logic       q_empty,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_done,
	output logic       malformed,
	output logic       last_of_item
);

	logic [1:0] idx_q;
	res_t       cur;
	logic       fire;

	assign cur = head.res[idx_q];
	assign out_valid = !q_empty;
	assign out_byte = cur.data;
	assign byte_valid = cur.valid;
	assign string_done = cur.done;
	assign malformed = cur.bad;
	assign last_of_item = ({1'b0, idx_q} == head.cnt - 3'd1);
	assign fire = out_valid && out_ready;
	assign q_pop = fire && last_of_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= last_of_item ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
